// ===== sv/selective_repeat_receiver_defines.svh =====
// Assertion macros for the selective-repeat receiver checkers.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SRRX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define SRRX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/srrx_pkg.sv =====
// Package: constants, types and control structs of the selective-repeat receiver.
package srrx_pkg;

  localparam int unsigned SEQ_SPACE    = 8;
  localparam int unsigned SEQ_W        = $clog2(SEQ_SPACE);
  localparam int unsigned SEQ_FIELD_W  = 3;
  localparam int unsigned PAYLOAD_BITS = 64;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned WIN_W        = 3;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);
  localparam int unsigned MAX_DELIVER  = (SEQ_SPACE - 1 < 7) ? SEQ_SPACE - 1 : 7;
  localparam int unsigned CNT_W        = $clog2(MAX_DELIVER);

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic {
    KIND_ACK = 1'b0,
    KIND_DLV = 1'b1
  } kind_e;

  typedef struct packed {
    logic in_valid;
    logic checksum_ok;
    logic at_base;
    logic out_free;
    logic run_last;
  } srrx_status_t;

  typedef struct packed {
    logic in_ready;
    logic deliver;
    logic from_hold;
    logic last;
  } srrx_cmd_t;

endpackage

// ===== sv/srrx_in_if.sv =====
// Interface: packet channel into the receiver.
interface srrx_in_if;
  import srrx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SEQ_FIELD_W-1:0] seq_num;
  logic                   checksum_ok;
  logic [DATA_W-1:0]      payload;

  modport source (output valid, seq_num, checksum_ok, payload, input ready);
  modport sink   (input valid, seq_num, checksum_ok, payload, output ready);
endinterface

// ===== sv/srrx_out_if.sv =====
// Interface: result channel out of the receiver.
interface srrx_out_if;
  import srrx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SEQ_FIELD_W-1:0] ack_num;
  logic [DATA_W-1:0]      data;
  logic                   last;

  modport source (output valid, kind, ack_num, data, last, input ready);
  modport sink   (input valid, kind, ack_num, data, last, output ready);
endinterface

// ===== sv/srrx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srrx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/srrx_dp.sv =====
// Datapath: window register, base pointer, received flags, payload RAM, result register.
module srrx_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             window_size_we_i,
  input  logic [srrx_pkg::WIN_W-1:0]       window_size_i,
  input  logic                             in_valid_i,
  input  logic [srrx_pkg::SEQ_FIELD_W-1:0] seq_num_i,
  input  logic                             checksum_ok_i,
  input  logic [srrx_pkg::DATA_W-1:0]      payload_i,
  input  srrx_pkg::srrx_cmd_t              cmd_i,
  output srrx_pkg::srrx_status_t           status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output srrx_pkg::kind_e                  kind_o,
  output logic [srrx_pkg::SEQ_FIELD_W-1:0] ack_num_o,
  output logic [srrx_pkg::DATA_W-1:0]      data_o,
  output logic                             last_o
);
  import srrx_pkg::*;

  logic [WIN_W-1:0]        win_q;
  logic [WIN_W-1:0]        eff_win;
  seq_t                    base_q;
  seq_t                    base_nx;
  seq_t                    seq_idx;
  seq_t                    seq_off;
  logic [SEQ_SPACE-1:0]    flags_q;
  logic [PAYLOAD_BITS-1:0] hold_q;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic                    accept;
  logic                    good;
  logic                    at_base;
  logic                    in_win;
  logic                    store;
  logic                    ram_re;
  logic                    out_free;

  logic                    out_valid_q;
  kind_e                   kind_q;
  logic [SEQ_FIELD_W-1:0]  ack_num_q;
  logic [DATA_W-1:0]       data_q;
  logic                    last_q;

  // window is capped below the sequence space
  assign eff_win = (int'(win_q) > int'(SEQ_SPACE - 1)) ? WIN_W'(SEQ_SPACE - 1) : win_q;

  assign seq_idx  = seq_num_i[SEQ_W-1:0];
  assign seq_off  = seq_idx - base_q;
  assign base_nx  = base_q + SEQ_W'(1);
  assign accept   = in_valid_i && cmd_i.in_ready;
  assign good     = accept && checksum_ok_i;
  assign at_base  = (seq_idx == base_q);
  assign in_win   = int'(seq_off) < int'(eff_win);
  assign store    = good && (at_base || in_win);
  assign out_free = !out_valid_q || out_ready_i;

  // read one word ahead: at base accept and at each delivery taken from RAM
  assign ram_re = (good && at_base) || (cmd_i.deliver && !cmd_i.from_hold);

  srrx_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SEQ_SPACE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (seq_idx),
    .wdata_i (payload_i[PAYLOAD_BITS-1:0]),
    .re_i    (ram_re),
    .raddr_i (base_nx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_RESET;
      base_q      <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (window_size_we_i) begin
        win_q <= window_size_i;
      end
      if (store) begin
        flags_q[seq_idx] <= 1'b1;
      end
      if (cmd_i.deliver) begin
        flags_q[base_q] <= 1'b0;
        base_q          <= base_nx;
      end
      if (good || cmd_i.deliver) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (good && at_base) begin
      hold_q <= payload_i[PAYLOAD_BITS-1:0];
    end
    if (good) begin
      kind_q    <= KIND_ACK;
      ack_num_q <= seq_num_i;
      data_q    <= '0;
      last_q    <= !at_base;
    end else if (cmd_i.deliver) begin
      kind_q    <= KIND_DLV;
      ack_num_q <= '0;
      data_q    <= cmd_i.from_hold ? DATA_W'(hold_q) : DATA_W'(ram_rdata);
      last_q    <= cmd_i.last;
    end
  end

  assign status_o.in_valid    = in_valid_i;
  assign status_o.checksum_ok = checksum_ok_i;
  assign status_o.at_base     = at_base;
  assign status_o.out_free    = out_free;
  assign status_o.run_last    = !flags_q[base_nx];

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign ack_num_o   = ack_num_q;
  assign data_o      = data_q;
  assign last_o      = last_q;
endmodule

// ===== sv/srrx_ctrl.sv =====
// Controller: accepts packets and sequences the in-order delivery run.
module srrx_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  srrx_pkg::srrx_status_t status_i,
  output srrx_pkg::srrx_cmd_t    cmd_o
);
  import srrx_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DLV  = 2'b10
  } state_e;

  state_e           state_q;
  state_e           state_d;
  logic             first_q;
  logic [CNT_W-1:0] cnt_q;
  logic             start_run;

  assign start_run = (state_q == ST_IDLE) && status_i.in_valid && status_i.out_free &&
                     status_i.checksum_ok && status_i.at_base;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = status_i.out_free;
        if (start_run) begin
          state_d = ST_DLV;
        end
      end
      ST_DLV: begin
        cmd_o.deliver   = status_i.out_free;
        cmd_o.from_hold = first_q;
        cmd_o.last      = status_i.run_last || (cnt_q == CNT_W'(MAX_DELIVER - 1));
        if (cmd_o.deliver && cmd_o.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (start_run) begin
        first_q <= 1'b1;
        cnt_q   <= '0;
      end else if (cmd_o.deliver) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q + CNT_W'(1);
      end
    end
  end
endmodule

// ===== sv/selective_repeat_receiver.sv =====
// Top level of the selective-repeat receiver: controller plus datapath.
//
//  channel   dir  handshake      payload
//  pkt_i     in   valid/ready    seq_num, checksum_ok, payload
//  res_o     out  valid/ready    kind, ack_num, data, last
//  window    in   we only        window_size_i (3 bits)
//
// A packet off the base yields only its acknowledgement; a packet at the base
// yields it and then k deliveries, one word per cycle unless res_o stalls, the
// first from a hold register and the rest from the payload RAM read port.
// Reset: base 0, all received flags clear, window 4; no clearing pass.
// pkt_i.ready is low while a result waits with res_o.ready low and during a
// delivery run; a stalled result holds its fields.
module selective_repeat_receiver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       window_size_we_i,
  input  logic [srrx_pkg::WIN_W-1:0] window_size_i,
  srrx_in_if.sink                    pkt_i,
  srrx_out_if.source                 res_o
);
  import srrx_pkg::*;

  srrx_cmd_t    cmd;
  srrx_status_t status;
  kind_e        kind;

  srrx_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  srrx_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_size_we_i (window_size_we_i),
    .window_size_i    (window_size_i),
    .in_valid_i       (pkt_i.valid),
    .seq_num_i        (pkt_i.seq_num),
    .checksum_ok_i    (pkt_i.checksum_ok),
    .payload_i        (pkt_i.payload),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .kind_o           (kind),
    .ack_num_o        (res_o.ack_num),
    .data_o           (res_o.data),
    .last_o           (res_o.last)
  );

  assign pkt_i.ready = cmd.in_ready;
  assign res_o.kind  = kind;
endmodule

// ===== sv/srrx_chk.sv =====
// Checker on the receiver's ports, bound to the top level.
`include "selective_repeat_receiver_defines.svh"

module srrx_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             pkt_valid_i,
  input logic                             pkt_ready_i,
  input logic                             pkt_checksum_ok_i,
  input logic                             res_valid_i,
  input logic                             res_ready_i,
  input logic                             res_kind_i,
  input logic [srrx_pkg::SEQ_FIELD_W-1:0] res_ack_num_i,
  input logic [srrx_pkg::DATA_W-1:0]      res_data_i,
  input logic                             res_last_i
);
  import srrx_pkg::*;

  logic pkt_txn;
  logic res_txn;

  assign pkt_txn = pkt_valid_i && pkt_ready_i;
  assign res_txn = res_valid_i && res_ready_i;

  `SRRX_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_kind_i) && $stable(res_last_i) && $stable(res_ack_num_i) && $stable(res_data_i), "stalled result changed")
  `SRRX_ASSERT_NXT(a_ack_next, pkt_txn && pkt_checksum_ok_i, res_valid_i && res_kind_i == KIND_ACK, "good packet not acknowledged next cycle")
  `SRRX_ASSERT_NXT(a_run_cont, res_txn && !res_last_i, res_valid_i && res_kind_i == KIND_DLV, "delivery run broken")
  `SRRX_ASSERT_IMP(a_run_block, res_valid_i && !res_last_i, !pkt_ready_i, "packet taken during delivery run")
endmodule

bind selective_repeat_receiver srrx_chk u_srrx_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .pkt_valid_i       (pkt_i.valid),
  .pkt_ready_i       (pkt_i.ready),
  .pkt_checksum_ok_i (pkt_i.checksum_ok),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_kind_i        (res_o.kind),
  .res_ack_num_i     (res_o.ack_num),
  .res_data_i        (res_o.data),
  .res_last_i        (res_o.last)
);

// ===== tb/selective_repeat_receiver_tb.sv =====
// Testbench for the selective-repeat receiver: directed and random packets against a predictor.
`timescale 1ns / 100ps

module selective_repeat_receiver_tb;
  import srrx_pkg::*;

  typedef struct packed {
    kind_e                  kind;
    logic [SEQ_FIELD_W-1:0] ack_num;
    logic [DATA_W-1:0]      data;
    logic                   last;
  } rx_result_t;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             window_size_we_i = 1'b0;
  logic [WIN_W-1:0] window_size_i    = '0;

  srrx_in_if  pkt_if ();
  srrx_out_if res_if ();

  selective_repeat_receiver u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .window_size_we_i (window_size_we_i),
    .window_size_i    (window_size_i),
    .pkt_i            (pkt_if),
    .res_o            (res_if)
  );

  // receiver state as predicted
  logic [WIN_W-1:0]  rx_window = WIN_RESET;
  seq_t              rx_base   = '0;
  logic              rx_have [SEQ_SPACE] = '{default: 1'b0};
  logic [DATA_W-1:0] rx_word [SEQ_SPACE] = '{default: '0};
  rx_result_t        awaited_results [$];

  int unsigned error_count     = 0;
  int unsigned pkts_accepted   = 0;
  int unsigned results_checked = 0;
  int unsigned deliveries_seen = 0;
  int unsigned window_writes   = 0;

  bit          idle_en     = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned stall_left  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void compute_packet_results(input logic [SEQ_FIELD_W-1:0] seq_raw,
                                                 input logic ok,
                                                 input logic [DATA_W-1:0] payload);
    rx_result_t        batch [$];
    rx_result_t        r;
    seq_t              seq;
    logic [DATA_W-1:0] word;
    int unsigned       win;
    int unsigned       seq_off;
    int unsigned       n;
    seq  = seq_t'(seq_raw % SEQ_SPACE);
    word = payload & ({DATA_W{1'b1}} >> (DATA_W - PAYLOAD_BITS));
    win  = (rx_window > SEQ_SPACE - 1) ? SEQ_SPACE - 1 : rx_window;
    n    = 0;
    if (!ok) return;
    r.kind    = KIND_ACK;
    r.ack_num = seq_raw;
    r.data    = '0;
    r.last    = 1'b0;
    batch.push_back(r);
    if (seq == rx_base) begin
      rx_have[seq] = 1'b1;
      rx_word[seq] = word;
      while (rx_have[rx_base] && n < MAX_DELIVER) begin
        r.kind    = KIND_DLV;
        r.ack_num = '0;
        r.data    = rx_word[rx_base];
        batch.push_back(r);
        n++;
        rx_have[rx_base] = 1'b0;
        rx_base          = seq_t'((rx_base + 1) % SEQ_SPACE);
      end
    end else begin
      seq_off = (int'(seq) + SEQ_SPACE - int'(rx_base)) % SEQ_SPACE;
      if (seq_off < win) begin
        rx_word[seq] = word;
        rx_have[seq] = 1'b1;
      end
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) awaited_results.push_back(batch[i]);
  endfunction

  // predict on each accepted packet, then check each accepted result
  always @(posedge clk_i) begin : monitor_blk
    rx_result_t exp_r;
    if (rst_ni) begin
      if (window_size_we_i) rx_window = window_size_i;
      if (pkt_if.valid && pkt_if.ready) begin
        pkts_accepted++;
        compute_packet_results(pkt_if.seq_num, pkt_if.checksum_ok, pkt_if.payload);
      end
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0b ack=%0d data=%h",
                                    res_if.kind, res_if.ack_num, res_if.data));
        end else begin
          exp_r = awaited_results.pop_front();
          results_checked++;
          if (exp_r.kind == KIND_DLV) deliveries_seen++;
          if (res_if.kind !== exp_r.kind)
            report_mismatch($sformatf("kind got %0b want %0b", res_if.kind, exp_r.kind));
          if (res_if.ack_num !== exp_r.ack_num)
            report_mismatch($sformatf("ack_num got %0d want %0d", res_if.ack_num,
                                      exp_r.ack_num));
          if (res_if.data !== exp_r.data)
            report_mismatch($sformatf("data got %h want %h", res_if.data, exp_r.data));
          if (res_if.last !== exp_r.last)
            report_mismatch($sformatf("last got %0b want %0b", res_if.last, exp_r.last));
        end
      end
    end
  end

  // result side: random stall bursts plus long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        hold_cycles--;
        res_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 4);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_packet(input logic [SEQ_FIELD_W-1:0] seq, input logic ok,
                             input logic [DATA_W-1:0] payload);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      pkt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pkt_if.valid       <= 1'b1;
    pkt_if.seq_num     <= seq;
    pkt_if.checksum_ok <= ok;
    pkt_if.payload     <= payload;
    do @(posedge clk_i); while (pkt_if.ready !== 1'b1);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    pkt_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    // a dropped packet leaves no result behind, so wait on after the queue is empty
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] win);
    wait_for_drain();
    window_size_we_i <= 1'b1;
    window_size_i    <= win;
    @(negedge clk_i);
    window_size_we_i <= 1'b0;
    window_writes++;
  endtask

  task automatic test_reset_window_cases();
    send_packet(3'd0, 1'b1, {DATA_W{1'b1}});
    send_packet(3'd1, 1'b0, '0);                   // bad checksum
    send_packet(3'd3, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_packet(3'd2, 1'b1, 64'h5555_5555_5555_5555);
    send_packet(3'd1, 1'b1, '0);                   // releases 1..3
    send_packet(3'd0, 1'b1, {$urandom, $urandom}); // just past the window
    send_packet(3'd3, 1'b1, {$urandom, $urandom}); // already delivered
    send_packet(3'd5, 1'b1, 64'h0123_4567_89AB_CDEF);
    send_packet(3'd5, 1'b1, 64'hFEDC_BA98_7654_3210); // duplicate overwrites
    send_packet(3'd4, 1'b1, 64'h8000_0000_0000_0001);
    send_packet(3'd6, 1'b0, {DATA_W{1'b1}});       // bad checksum at base
  endtask

  task automatic test_window_extremes();
    set_window(3'd0);
    send_packet(3'd7, 1'b1, {$urandom, $urandom});
    send_packet(3'd6, 1'b1, {$urandom, $urandom});
    set_window(3'd7);
    for (int i = 0; i < 6; i++) send_packet(3'(i), 1'b1, {$urandom, $urandom});
    send_packet(3'd7, 1'b1, {$urandom, $urandom}); // full run of seven deliveries
    set_window(3'd1);
    send_packet(3'd7, 1'b1, {$urandom, $urandom});
    send_packet(3'd6, 1'b1, {$urandom, $urandom});
  endtask

  task automatic test_random_traffic(input int unsigned count, input logic [WIN_W-1:0] win);
    logic [SEQ_FIELD_W-1:0] seq;
    int unsigned            pick;
    set_window(win);
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 3 || rx_window == 0)
        seq = SEQ_FIELD_W'(rx_base);
      else if (pick < 8)
        seq = SEQ_FIELD_W'(rx_base + $urandom_range(1, rx_window));
      else
        seq = SEQ_FIELD_W'($urandom_range(0, SEQ_SPACE - 1));
      send_packet(seq, $urandom_range(0, 9) != 0, {$urandom, $urandom});
    end
  endtask

  task automatic test_output_backpressure();
    set_window(3'd7);
    @(posedge clk_i);
    hold_cycles = 60;
    repeat (12)
      send_packet(SEQ_FIELD_W'(rx_base + $urandom_range(0, 3)), 1'b1, {$urandom, $urandom});
  endtask

  initial begin
    pkt_if.valid       = 1'b0;
    pkt_if.seq_num     = '0;
    pkt_if.checksum_ok = 1'b0;
    pkt_if.payload     = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_window_cases();
    test_window_extremes();
    test_random_traffic(25, 3'd4);
    test_random_traffic(25, 3'd7);
    test_random_traffic(20, 3'd1);
    test_random_traffic(20, 3'd0);
    test_random_traffic(20, 3'($urandom_range(0, 7)));
    test_output_backpressure();
    idle_en = 1'b0;
    test_random_traffic(25, 3'd3);
    wait_for_drain();

    $display("Run covered %0d packets, %0d results checked, %0d of them deliveries.",
             pkts_accepted, results_checked, deliveries_seen);
    $display("Window was rewritten %0d times, with bad checksums, duplicates and a long stall.",
             window_writes);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
